### sv/stm_pkg.sv
// ----------------------------------------------------------------------------
// stm_pkg
// Shared types, character codes, name ROM and scan function for the SQL text
// minifier.
// ----------------------------------------------------------------------------
package stm_pkg;

    localparam int DEF_MAX_NAME_LEN = 32;
    localparam int DEF_NAME_COUNT   = 3;

    // name ROM geometry
    localparam int ROM_SLOTS   = 16;
    localparam int ROM_SLOT_W  = 4;
    localparam int KEY_BYTES   = 22;
    localparam int TEXT_BYTES  = 55;
    localparam int KEY_LEN_W   = 5;
    localparam int TEXT_LEN_W  = 6;
    localparam int KEY_IDX_W   = 7;   // covers name lengths up to 127

    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] WORD_BYTE     = 8'h80;

    typedef logic [8*KEY_BYTES-1:0]  t_key_bits;
    typedef logic [8*TEXT_BYTES-1:0] t_text_bits;

    // ASCII, right-justified: the last character sits in the low byte
    localparam t_key_bits ROM_KEY [ROM_SLOTS] = '{
        0: 176'h41_44_44_45_52_5F_41_43_43_4F_55_4E_54_53_5F_43_4F_4C_55_4D_4E_53,
        1: 176'h41_44_44_45_52_5F_41_52_54_57_4F_52_4B_53_5F_43_4F_4C_55_4D_4E_53,
        2: 160'h41_44_44_45_52_5F_43_4F_4D_49_43_53_5F_43_4F_4C_55_4D_4E_53,
        default: '0
    };
    localparam logic [KEY_LEN_W-1:0] ROM_KEY_LEN [ROM_SLOTS] = '{
        0: 5'd22, 1: 5'd22, 2: 5'd20, default: '0
    };
    localparam t_text_bits ROM_TEXT [ROM_SLOTS] = '{
        0: 80'h61_63_63_5F_61_72_63_6F_69_64,
        1: {88'h61_72_74_5F_61_72_74_69_64_2C_20,
            88'h61_72_74_5F_66_6C_61_67_30_2C_20,
            96'h61_72_74_5F_70_61_72_74_6F_66_2C_20,
            96'h61_72_74_5F_70_61_67_65_6E_6F_2C_20,
            72'h61_72_74_5F_64_77_6E_69_64},
        2: 80'h63_6F_6D_5F_61_72_63_6F_69_64,
        default: '0
    };
    localparam logic [TEXT_LEN_W-1:0] ROM_TEXT_LEN [ROM_SLOTS] = '{
        0: 6'd10, 1: 6'd55, 2: 6'd10, default: '0
    };

    typedef enum logic [2:0] {
        ST_NORMAL  = 3'd0,
        ST_SLASH   = 3'd1,
        ST_COMMENT = 3'd2,
        ST_STAR    = 3'd3,
        ST_STRING  = 3'd4,
        ST_NAME    = 3'd5
    } t_scan_state;

    typedef struct packed {
        t_scan_state state;
        logic        need;
        logic        was;
    } t_scan_regs;

    typedef struct packed {
        t_scan_regs  nxt;
        logic [1:0]  cnt;
        logic [7:0]  e0;
        logic [7:0]  e1;
        logic        enter_name;
    } t_scan_out;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       unknown_name;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPAND,
        S_EXPAND_EOT,
        S_TAIL,
        S_FIN,
        S_FIN_CLEAR
    } t_ctl_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SCAN,
        OP_NAME_CHAR,
        OP_NAME_HIT,
        OP_NAME_MISS,
        OP_EOT_HIT,
        OP_EOT_MISS,
        OP_EOT_CLEAR,
        OP_FINISH,
        OP_FINISH_CLEAR
    } t_dp_op;

    typedef enum logic [1:0] {
        SRC_IN,
        SRC_TEXT,
        SRC_HELD
    } t_src;

    typedef struct packed {
        t_dp_op op;
        t_src   src;
        logic   finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic in_eot;
        logic in_name;
        logic name_char;
        logic name_hit;
        logic step_done;
        logic text_last;
    } t_dp_stat;

    function automatic logic is_word(logic [7:0] b);
        return (b >= WORD_BYTE) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9");
    endfunction

    function automatic logic is_name_char(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b == CH_UNDERSCORE);
    endfunction

    function automatic logic [7:0] key_char(logic [ROM_SLOT_W-1:0] k,
                                            logic [KEY_IDX_W-1:0] idx);
        logic [KEY_IDX_W-1:0] klen;
        t_key_bits            sh;
        klen = KEY_IDX_W'(ROM_KEY_LEN[k]);
        sh   = '0;
        if (idx < klen) begin
            sh = ROM_KEY[k] >> {klen - KEY_IDX_W'(1) - idx, 3'b000};
        end
        return sh[7:0];
    endfunction

    function automatic logic [7:0] text_char(logic [ROM_SLOT_W-1:0] k,
                                             logic [TEXT_LEN_W-1:0] idx);
        t_text_bits sh;
        sh = ROM_TEXT[k] >> {ROM_TEXT_LEN[k] - TEXT_LEN_W'(1) - idx, 3'b000};
        return sh[7:0];
    endfunction

    // One byte through every scanner state except the name state.
    function automatic t_scan_out scan_byte(t_scan_regs st, logic [7:0] b, logic [7:0] prev);
        t_scan_out o;
        logic      go;
        logic      blank;
        logic      w;
        o            = '0;
        o.nxt        = st;
        go           = 1'b0;
        blank        = 1'b0;
        w            = is_word(b);
        case (st.state)
            ST_COMMENT: begin
                if (b == CH_STAR) begin
                    o.nxt.state = ST_STAR;
                end
            end
            ST_STAR: begin
                o.nxt.state = (b == CH_SLASH) ? ST_NORMAL : ST_COMMENT;
            end
            ST_STRING: begin
                o.cnt = 2'd1;
                o.e0  = b;
                if (b == CH_QUOTE && prev != CH_BSLASH) begin
                    o.nxt.state = ST_NORMAL;
                    o.nxt.was   = 1'b0;
                    o.nxt.need  = 1'b0;
                end
            end
            ST_SLASH: begin
                if (b == CH_STAR) begin
                    o.nxt.state = ST_COMMENT;
                end else begin
                    o.cnt      = 2'd1;
                    o.e0       = CH_SLASH;
                    o.nxt.was  = 1'b0;
                    o.nxt.need = 1'b0;
                    go         = 1'b1;
                end
            end
            default: begin
                go = 1'b1;
            end
        endcase
        if (go) begin
            o.nxt.state = ST_NORMAL;
            case (b)
                CH_QUOTE: begin
                    if (o.cnt == 2'd0) o.e0 = b;
                    else               o.e1 = b;
                    o.cnt       = o.cnt + 2'd1;
                    o.nxt.state = ST_STRING;
                end
                CH_SLASH: begin
                    o.nxt.state = ST_SLASH;
                end
                CH_DOLLAR: begin
                    o.nxt.state  = ST_NAME;
                    o.enter_name = 1'b1;
                end
                CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                    blank = 1'b1;
                end
                default: begin
                    // a word after a blank run after a word keeps one space
                    if (o.nxt.need && o.nxt.was && w) begin
                        o.e0  = CH_SPACE;
                        o.cnt = 2'd1;
                    end
                    if (o.cnt == 2'd0) o.e0 = b;
                    else               o.e1 = b;
                    o.cnt      = o.cnt + 2'd1;
                    o.nxt.need = w;
                end
            endcase
            o.nxt.was = blank;
        end
        return o;
    endfunction

endpackage

### sv/stm_datapath.sv
// ----------------------------------------------------------------------------
// stm_datapath
// Scanner state, on-the-fly name matching, expansion text pointer, result
// hold stage and output register.
// ----------------------------------------------------------------------------
module stm_datapath #(
    parameter int MAX_NAME_LEN = stm_pkg::DEF_MAX_NAME_LEN,
    parameter int NAME_COUNT   = stm_pkg::DEF_NAME_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stm_pkg::t_in_item   i_data,
    input  stm_pkg::t_dp_cmd    i_cmd,
    output stm_pkg::t_dp_stat   o_stat,
    output logic                o_valid,
    input  logic                i_ready,
    output stm_pkg::t_out_item  o_data
);
    import stm_pkg::*;

    localparam int LEN_W = $clog2(MAX_NAME_LEN + 1);

    t_scan_regs              r_st, n_st;
    logic [7:0]              r_prev, n_prev;
    logic [7:0]              r_byte, n_byte;
    logic [LEN_W-1:0]        r_len, n_len;
    logic                    r_over, n_over;
    logic [NAME_COUNT-1:0]   r_match, n_match;
    logic [ROM_SLOT_W-1:0]   r_key, n_key;
    logic [TEXT_LEN_W-1:0]   r_tidx, n_tidx;
    logic [7:0]              r_tprev, n_tprev;
    logic                    r_half, n_half;
    logic                    r_pv, n_pv;
    t_out_item               r_pend, n_pend;
    logic                    r_ov, n_ov;
    t_out_item               r_out, n_out;

    logic [7:0]              in_byte;
    logic [7:0]              text_c;
    logic [7:0]              sb;
    logic [7:0]              sp;
    t_scan_out               sr;
    logic                    step_done;
    logic                    hit;
    logic [ROM_SLOT_W-1:0]   hit_k;
    logic                    emit_v;
    logic [7:0]              emit_b;
    logic                    emit_err;

    assign in_byte = i_data.data_byte;
    assign text_c  = text_char(r_key, r_tidx);

    always_comb begin
        case (i_cmd.src)
            SRC_IN: begin
                sb = in_byte;
                sp = r_prev;
            end
            SRC_TEXT: begin
                sb = text_c;
                sp = r_tprev;
            end
            default: begin
                sb = r_byte;
                sp = r_prev;
            end
        endcase
    end

    assign sr        = scan_byte(r_st, sb, sp);
    assign step_done = !(sr.cnt == 2'd2 && !r_half);

    // lowest matching entry wins
    always_comb begin
        hit   = 1'b0;
        hit_k = '0;
        for (int k = NAME_COUNT - 1; k >= 0; k--) begin
            if (r_match[k] && KEY_IDX_W'(r_len) == KEY_IDX_W'(ROM_KEY_LEN[k])) begin
                hit   = 1'b1;
                hit_k = ROM_SLOT_W'(k);
            end
        end
        if (r_over || r_len == '0) begin
            hit = 1'b0;
        end
    end

    always_comb begin
        o_stat.out_free  = !r_ov || i_ready;
        o_stat.in_eot    = i_data.end_of_text;
        o_stat.in_name   = (r_st.state == ST_NAME);
        o_stat.name_char = is_name_char(in_byte);
        o_stat.name_hit  = hit;
        o_stat.step_done = step_done;
        o_stat.text_last = (r_tidx == ROM_TEXT_LEN[r_key] - TEXT_LEN_W'(1));
    end

    always_comb begin
        n_st     = r_st;
        n_prev   = r_prev;
        n_byte   = r_byte;
        n_len    = r_len;
        n_over   = r_over;
        n_match  = r_match;
        n_key    = r_key;
        n_tidx   = r_tidx;
        n_tprev  = r_tprev;
        n_half   = r_half;
        n_pv     = r_pv;
        n_pend   = r_pend;
        n_ov     = r_ov && !i_ready;
        n_out    = r_out;
        emit_v   = 1'b0;
        emit_b   = 8'h00;
        emit_err = 1'b0;

        case (i_cmd.op)
            OP_SCAN: begin
                if (i_cmd.src == SRC_IN) begin
                    n_byte = in_byte;
                end
                if (!step_done) begin
                    // first of two words; hold state and rescan the same byte
                    emit_v = 1'b1;
                    emit_b = sr.e0;
                    n_half = 1'b1;
                end else begin
                    n_half = 1'b0;
                    emit_v = (sr.cnt != 2'd0);
                    emit_b = r_half ? sr.e1 : sr.e0;
                    n_st   = sr.nxt;
                    if (sr.enter_name) begin
                        n_len   = '0;
                        n_over  = 1'b0;
                        n_match = '1;
                    end
                    case (i_cmd.src)
                        SRC_IN:   n_prev = in_byte;
                        SRC_TEXT: begin
                            n_tprev = text_c;
                            n_tidx  = r_tidx + TEXT_LEN_W'(1);
                        end
                        default:  n_prev = r_byte;
                    endcase
                end
            end
            OP_NAME_CHAR: begin
                if (r_len < LEN_W'(MAX_NAME_LEN)) begin
                    n_len = r_len + LEN_W'(1);
                    for (int k = 0; k < NAME_COUNT; k++) begin
                        n_match[k] = r_match[k] &&
                            (key_char(ROM_SLOT_W'(k), KEY_IDX_W'(r_len)) == in_byte);
                    end
                end else begin
                    n_over = 1'b1;
                end
                n_prev = in_byte;
            end
            OP_NAME_HIT: begin
                emit_v     = 1'b1;
                emit_b     = CH_SPACE;
                n_key      = hit_k;
                n_tidx     = '0;
                n_tprev    = 8'h00;
                n_st.state = ST_NORMAL;
                n_byte     = in_byte;
            end
            OP_NAME_MISS: begin
                emit_v     = 1'b1;
                emit_err   = 1'b1;
                n_st.state = ST_NORMAL;
                n_prev     = in_byte;
            end
            OP_EOT_HIT: begin
                n_key      = hit_k;
                n_tidx     = '0;
                n_tprev    = 8'h00;
                n_st.state = ST_NORMAL;
            end
            OP_EOT_MISS, OP_EOT_CLEAR, OP_FINISH_CLEAR: begin
                emit_v   = (i_cmd.op == OP_EOT_MISS);
                emit_err = (i_cmd.op == OP_EOT_MISS);
                n_st     = '{state: ST_NORMAL, need: 1'b0, was: 1'b0};
                n_prev   = 8'h00;
                n_len    = '0;
                n_over   = 1'b0;
            end
            default: begin
            end
        endcase

        // hold one word back so the last word of an item can be marked
        if (i_cmd.finish) begin
            if (emit_v) begin
                n_out = '{out_byte: emit_b, last_of_run: 1'b1, unknown_name: emit_err};
                n_ov  = 1'b1;
            end else if (r_pv) begin
                n_out = '{out_byte: r_pend.out_byte, last_of_run: 1'b1,
                          unknown_name: r_pend.unknown_name};
                n_ov  = 1'b1;
            end
            n_pv = 1'b0;
        end else if (emit_v) begin
            if (r_pv) begin
                n_out = '{out_byte: r_pend.out_byte, last_of_run: 1'b0,
                          unknown_name: r_pend.unknown_name};
                n_ov  = 1'b1;
            end
            n_pv   = 1'b1;
            n_pend = '{out_byte: emit_b, last_of_run: 1'b0, unknown_name: emit_err};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= '{state: ST_NORMAL, need: 1'b0, was: 1'b0};
            r_prev  <= 8'h00;
            r_len   <= '0;
            r_over  <= 1'b0;
            r_key   <= '0;
            r_tidx  <= '0;
            r_tprev <= 8'h00;
            r_half  <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_prev  <= n_prev;
            r_len   <= n_len;
            r_over  <= n_over;
            r_key   <= n_key;
            r_tidx  <= n_tidx;
            r_tprev <= n_tprev;
            r_half  <= n_half;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_match <= n_match;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

### sv/stm_ctrl.sv
// ----------------------------------------------------------------------------
// stm_ctrl
// Sequencer: takes input words, walks a name expansion one text byte at a
// time, rescans the held terminator and closes each item.
// ----------------------------------------------------------------------------
module stm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  stm_pkg::t_dp_stat  i_stat,
    output stm_pkg::t_dp_cmd   o_cmd
);
    import stm_pkg::*;

    t_ctl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_cmd.op     = OP_NONE;
        o_cmd.finish = 1'b0;
        case (r_state)
            S_IDLE:                 o_cmd.src = SRC_IN;
            S_EXPAND, S_EXPAND_EOT: o_cmd.src = SRC_TEXT;
            default:                o_cmd.src = SRC_HELD;
        endcase

        case (r_state)
            S_IDLE: begin
                o_ready = i_stat.out_free;
                if (i_valid && i_stat.out_free) begin
                    if (i_stat.in_eot) begin
                        if (i_stat.in_name && i_stat.name_hit) begin
                            o_cmd.op = OP_EOT_HIT;
                            n_state  = S_EXPAND_EOT;
                        end else if (i_stat.in_name) begin
                            o_cmd.op     = OP_EOT_MISS;
                            o_cmd.finish = 1'b1;
                        end else begin
                            o_cmd.op     = OP_EOT_CLEAR;
                            o_cmd.finish = 1'b1;
                        end
                    end else if (i_stat.in_name) begin
                        if (i_stat.name_char) begin
                            o_cmd.op     = OP_NAME_CHAR;
                            o_cmd.finish = 1'b1;
                        end else if (i_stat.name_hit) begin
                            o_cmd.op = OP_NAME_HIT;
                            n_state  = S_EXPAND;
                        end else begin
                            o_cmd.op     = OP_NAME_MISS;
                            o_cmd.finish = 1'b1;
                        end
                    end else begin
                        o_cmd.op = OP_SCAN;
                        if (i_stat.step_done) begin
                            o_cmd.finish = 1'b1;
                        end else begin
                            n_state = S_TAIL;
                        end
                    end
                end
            end
            S_EXPAND, S_EXPAND_EOT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_SCAN;
                    if (i_stat.step_done && i_stat.text_last) begin
                        n_state = (r_state == S_EXPAND_EOT) ? S_FIN_CLEAR : S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_SCAN;
                    if (i_stat.step_done) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.op     = OP_FINISH;
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FIN_CLEAR: begin
                if (i_stat.out_free) begin
                    o_cmd.op     = OP_FINISH_CLEAR;
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/sql_text_minifier.sv
// ----------------------------------------------------------------------------
// sql_text_minifier
// Minifies SQL text a byte at a time and expands dollar names from a ROM.
// ----------------------------------------------------------------------------
// A text byte that yields zero or one output byte is scanned once and closes
// the item; one that yields two (a held slash plus the byte, or a space plus
// a word byte) is scanned again from the held byte for the second and then
// closed in its own step. A byte that ends a dollar name emits the leading
// space, walks the expansion text a byte at a time (scanning a byte again
// where it yields two output bytes), rescans the terminating byte and closes
// the item; end of text inside a name is accepted, walks the same expansion
// and closes the item. An unknown name, or end of text outside a name, closes
// the item as it is accepted. At most one output word per cycle, none while
// the output is stalled, enters a single output register, and one word is
// held back to mark the last word of each item. Input stalls while the
// output register is full and not taken. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module sql_text_minifier #(
    parameter int MAX_NAME_LEN = stm_pkg::DEF_MAX_NAME_LEN,
    parameter int NAME_COUNT   = stm_pkg::DEF_NAME_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  stm_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output stm_pkg::t_out_item  o_data
);
    import stm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    stm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    stm_datapath #(
        .MAX_NAME_LEN (MAX_NAME_LEN),
        .NAME_COUNT   (NAME_COUNT)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sql_text_minifier. A short directed table and a
// long run of random SQL fragments (dollar names, comments, quoted strings,
// blanks, end-of-text marks, stray bytes) are fed one byte per word. An
// in-bench minifier predicts the output words, which are compared field by
// field as they leave the block. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import stm_pkg::*;

    localparam int MAX_NAME_LEN = 32;
    localparam int NAME_TOTAL   = 3;
    localparam int WORD_CAP     = 64;
    localparam int RANDOM_ITEMS = 425;
    localparam int HOLD_AT      = 120;
    localparam int PAUSE_AT     = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 2000000;

    localparam logic [7:0] K_SPACE  = " ";
    localparam logic [7:0] K_TAB    = "\t";
    localparam logic [7:0] K_LF     = "\n";
    localparam logic [7:0] K_CR     = "\r";
    localparam logic [7:0] K_QUOTE  = "'";
    localparam logic [7:0] K_SLASH  = "/";
    localparam logic [7:0] K_STAR   = "*";
    localparam logic [7:0] K_DOLLAR = "$";
    localparam logic [7:0] K_BSLASH = "\\";
    localparam logic [7:0] K_UNDER  = "_";

    typedef enum logic [1:0] {ROW_MODEL, ROW_ONE} t_row_kind;
    typedef enum int {RX_STEADY, RX_COIN, RX_MOSTLY, RX_SPARSE} t_rx_mode;

    typedef struct packed {
        logic [7:0] b;
        logic       eot;
        t_row_kind  kind;
        t_out_item  res;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [25] = '{
        '{"A",    1'b0, ROW_ONE,   '{"A", 1'b1, 1'b0}},
        '{8'hFF,  1'b0, ROW_ONE,   '{8'hFF, 1'b1, 1'b0}},
        '{" ",    1'b0, ROW_MODEL, '0},
        '{8'h80,  1'b0, ROW_MODEL, '0},
        '{8'h00,  1'b0, ROW_ONE,   '{8'h00, 1'b1, 1'b0}},
        '{"/",    1'b0, ROW_MODEL, '0},
        '{"*",    1'b0, ROW_MODEL, '0},
        '{"x",    1'b0, ROW_MODEL, '0},
        '{"*",    1'b0, ROW_MODEL, '0},
        '{"/",    1'b0, ROW_MODEL, '0},
        '{"/",    1'b0, ROW_MODEL, '0},
        '{"q",    1'b0, ROW_MODEL, '0},
        '{"'",    1'b0, ROW_MODEL, '0},
        '{"\\",   1'b0, ROW_MODEL, '0},
        '{"'",    1'b0, ROW_MODEL, '0},
        '{"'",    1'b0, ROW_MODEL, '0},
        '{"$",    1'b0, ROW_MODEL, '0},
        '{";",    1'b0, ROW_ONE,   '{8'h00, 1'b1, 1'b1}},
        '{"$",    1'b0, ROW_MODEL, '0},
        '{"a",    1'b0, ROW_MODEL, '0},
        '{"_",    1'b0, ROW_MODEL, '0},
        '{8'hFF,  1'b1, ROW_ONE,   '{8'h00, 1'b1, 1'b1}},
        '{"/",    1'b0, ROW_MODEL, '0},
        '{8'h00,  1'b1, ROW_MODEL, '0},
        '{"Z",    1'b0, ROW_MODEL, '0}
    };

    string name_key [NAME_TOTAL];
    string name_text [NAME_TOTAL];
    string punct_set = ",;()=<>.-+*/";
    string name_ends = " ,;)/'$\n*1";
    string blank_set = " \t\n\r";

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_in_item   i_data;
    logic       o_valid;
    logic       i_ready;
    t_out_item  o_data;

    // predictor state
    t_scan_state sc_state;
    logic        need_sp;
    logic        was_sp;
    logic [7:0]  prev_byte;
    logic [7:0]  nm_buf [MAX_NAME_LEN];
    int          nm_len;
    logic        nm_over;

    t_out_item   step_words [$];
    t_out_item   out_due [$];
    t_in_item    seg_q [$];

    int          errors = 0;
    int          burst_left = 0;
    logic        hold_req = 1'b0;
    int unsigned cycle_cnt = 0;

    sql_text_minifier i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Minifier predictor
    // ------------------------------------------------------------------------
    function automatic string rom_string(t_text_bits bits, int len);
        string      s;
        logic [7:0] c;
        s = "";
        for (int i = 0; i < len; i++) begin
            c = bits[8*(len-1-i) +: 8];
            s = $sformatf("%s%c", s, c);
        end
        return s;
    endfunction

    function automatic logic word_byte(logic [7:0] b);
        return b[7] || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9");
    endfunction

    function automatic logic name_byte(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == K_UNDER;
    endfunction

    task automatic put_word(logic [7:0] b, logic unk);
        if (step_words.size() < WORD_CAP) begin
            step_words.push_back(t_out_item'{b, 1'b0, unk});
        end
    endtask

    task automatic clear_state();
        sc_state  = ST_NORMAL;
        need_sp   = 1'b0;
        was_sp    = 1'b0;
        prev_byte = 8'h00;
        nm_len    = 0;
        nm_over   = 1'b0;
    endtask

    task automatic scan_text_byte(logic [7:0] b, logic [7:0] prev);
        logic blank;
        logic go;
        logic w;
        blank = 1'b0;
        go    = 1'b0;
        w     = word_byte(b);
        case (sc_state)
            ST_COMMENT: begin
                if (b == K_STAR) sc_state = ST_STAR;
            end
            ST_STAR: begin
                sc_state = (b == K_SLASH) ? ST_NORMAL : ST_COMMENT;
            end
            ST_STRING: begin
                put_word(b, 1'b0);
                if (b == K_QUOTE && prev != K_BSLASH) begin
                    sc_state = ST_NORMAL;
                    was_sp   = 1'b0;
                    need_sp  = 1'b0;
                end
            end
            ST_SLASH: begin
                if (b == K_STAR) begin
                    sc_state = ST_COMMENT;
                end else begin
                    // release the held slash, then treat b as plain text
                    put_word(K_SLASH, 1'b0);
                    was_sp  = 1'b0;
                    need_sp = 1'b0;
                    go      = 1'b1;
                end
            end
            default: go = 1'b1;
        endcase
        if (go) begin
            sc_state = ST_NORMAL;
            case (b)
                K_QUOTE: begin
                    put_word(b, 1'b0);
                    sc_state = ST_STRING;
                end
                K_SLASH:  sc_state = ST_SLASH;
                K_DOLLAR: begin
                    sc_state = ST_NAME;
                    nm_len   = 0;
                    nm_over  = 1'b0;
                end
                K_SPACE, K_TAB, K_LF, K_CR: blank = 1'b1;
                default: begin
                    if (need_sp && was_sp && w) put_word(K_SPACE, 1'b0);
                    put_word(b, 1'b0);
                    need_sp = w;
                end
            endcase
            was_sp = blank;
        end
    endtask

    function automatic int find_name();
        logic hit;
        if (nm_over || nm_len == 0) return -1;
        for (int k = 0; k < NAME_TOTAL; k++) begin
            if (name_key[k].len() == nm_len) begin
                hit = 1'b1;
                for (int i = 0; i < nm_len; i++) begin
                    if (nm_buf[i] != name_key[k][i]) hit = 1'b0;
                end
                if (hit) return k;
            end
        end
        return -1;
    endfunction

    task automatic expand_name(int k);
        logic [7:0] p;
        logic [7:0] c;
        p        = 8'h00;
        sc_state = ST_NORMAL;
        for (int i = 0; i < name_text[k].len(); i++) begin
            c = name_text[k][i];
            scan_text_byte(c, p);
            p = c;
        end
    endtask

    task automatic minify_step(t_in_item it);
        int k;
        step_words.delete();
        if (it.end_of_text) begin
            if (sc_state == ST_NAME) begin
                k = find_name();
                if (k >= 0) expand_name(k);
                else        put_word(8'h00, 1'b1);
            end
            clear_state();
        end else if (sc_state == ST_NAME) begin
            if (name_byte(it.data_byte)) begin
                if (nm_len < MAX_NAME_LEN) begin
                    nm_buf[nm_len] = it.data_byte;
                    nm_len++;
                end else begin
                    nm_over = 1'b1;
                end
            end else begin
                k = find_name();
                if (k < 0) begin
                    // drop the name and its terminator
                    put_word(8'h00, 1'b1);
                    sc_state = ST_NORMAL;
                end else begin
                    put_word(K_SPACE, 1'b0);
                    expand_name(k);
                    scan_text_byte(it.data_byte, prev_byte);
                end
            end
            prev_byte = it.data_byte;
        end else begin
            scan_text_byte(it.data_byte, prev_byte);
            prev_byte = it.data_byte;
        end
        if (step_words.size() > 0) step_words[step_words.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic post_expected();
        foreach (step_words[i]) out_due.push_back(step_words[i]);
    endtask

    // ------------------------------------------------------------------------
    // Random text fragments
    // ------------------------------------------------------------------------
    task automatic push_byte(logic [7:0] b);
        seg_q.push_back(t_in_item'{b, 1'b0});
    endtask

    task automatic push_eot();
        seg_q.push_back(t_in_item'{8'($urandom_range(0, 255)), 1'b1});
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_name_byte();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("A" + r);
        if (r < 52) return 8'("a" + r - 26);
        return K_UNDER;
    endfunction

    function automatic logic [7:0] rand_word_byte();
        case ($urandom_range(0, 3))
            0:       return 8'("a" + $urandom_range(0, 25));
            1:       return 8'("A" + $urandom_range(0, 25));
            2:       return 8'("0" + $urandom_range(0, 9));
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic logic [7:0] rand_non_name();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (name_byte(b)) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic end_name();
        if ($urandom_range(0, 5) == 0) push_eot();
        else if ($urandom_range(0, 1) == 0)
            push_byte(name_ends[$urandom_range(0, name_ends.len() - 1)]);
        else push_byte(rand_non_name());
    endtask

    task automatic build_segment();
        int    pick;
        int    n;
        string key;
        pick = $urandom_range(0, 99);
        key  = name_key[$urandom_range(0, NAME_TOTAL - 1)];
        if (pick < 25) begin
            push_byte(K_DOLLAR);
            push_text(key);
            end_name();
        end else if (pick < 35) begin
            // near misses, empty and overlong names
            push_byte(K_DOLLAR);
            n = $urandom_range(0, 3);
            if (n == 0) begin
                push_text(key.substr(0, key.len() - 1 - $urandom_range(1, 6)));
            end else if (n == 1) begin
                push_text(key);
                push_byte(rand_name_byte());
            end else begin
                n = (n == 2) ? $urandom_range(0, 8) : $urandom_range(30, 40);
                repeat (n) push_byte(rand_name_byte());
            end
            end_name();
        end else if (pick < 50) begin
            repeat ($urandom_range(1, 6)) push_byte(rand_word_byte());
        end else if (pick < 62) begin
            repeat ($urandom_range(1, 3))
                push_byte(blank_set[$urandom_range(0, blank_set.len() - 1)]);
        end else if (pick < 70) begin
            push_byte(punct_set[$urandom_range(0, punct_set.len() - 1)]);
        end else if (pick < 78) begin
            push_byte(K_SLASH);
            push_byte(K_STAR);
            repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) != 0) begin
                push_byte(K_STAR);
                push_byte(K_SLASH);
            end
        end else if (pick < 86) begin
            push_byte(K_QUOTE);
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 3) == 0) begin
                    push_byte(K_BSLASH);
                    push_byte(K_QUOTE);
                end else begin
                    n = $urandom_range(32, 125);
                    push_byte((8'(n) == K_QUOTE) ? K_SPACE : 8'(n));
                end
            end
            if ($urandom_range(0, 5) != 0) push_byte(K_QUOTE);
        end else if (pick < 91) begin
            push_eot();
        end else begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic idle_sender(int n);
        @(negedge i_clk);
        i_valid <= 1'b0;
        i_data  <= {8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))};
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain_sender();
        idle_sender(1);
        while (out_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic offer_item(t_in_item it);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 12));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        minify_step(it);
    endtask

    initial begin : stim
        int sent;
        for (int k = 0; k < NAME_TOTAL; k++) begin
            name_key[k]  = rom_string(t_text_bits'(ROM_KEY[k]), int'(ROM_KEY_LEN[k]));
            name_text[k] = rom_string(ROM_TEXT[k], int'(ROM_TEXT_LEN[k]));
        end
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        clear_state();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < $size(DIR_ROWS); r++) begin
            offer_item(t_in_item'{DIR_ROWS[r].b, DIR_ROWS[r].eot});
            case (DIR_ROWS[r].kind)
                ROW_MODEL: post_expected();
                ROW_ONE:   out_due.push_back(DIR_ROWS[r].res);
                default:   ;
            endcase
        end
        drain_sender();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (seg_q.size() == 0) build_segment();
            if (sent == HOLD_AT) begin
                // keep offering while the receiver holds off
                hold_req   = 1'b1;
                burst_left = 80;
            end
            if (sent == PAUSE_AT) drain_sender();
            offer_item(seg_q.pop_front());
            post_expected();
            sent++;
        end

        drain_sender();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------------
    initial begin : rx
        int       hold_left;
        int       run_left;
        t_rx_mode mode;
        hold_left = 0;
        run_left  = 0;
        mode      = RX_STEADY;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 3));
                    run_left = $urandom_range(8, 60);
                end
                run_left--;
                case (mode)
                    RX_STEADY: i_ready <= 1'b1;
                    RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: i_ready <= ($urandom_range(0, 7) != 0);
                    default:   i_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_out
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (out_due.size() == 0) begin
                $error("unexpected word: out_byte %02h", o_data.out_byte);
                errors++;
            end else begin
                want = out_due.pop_front();
                if (o_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h",
                           want.out_byte, o_data.out_byte);
                    errors++;
                end
                if (o_data.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %b, got %b",
                           want.last_of_run, o_data.last_of_run);
                    errors++;
                end
                if (o_data.unknown_name !== want.unknown_name) begin
                    $error("unknown_name: expected %b, got %b",
                           want.unknown_name, o_data.unknown_name);
                    errors++;
                end
            end
        end
    end

endmodule
